// File: rtl/pidaw_pkg.sv
// ----------------------------------------------------------------------------
// pidaw_pkg
// Types, constants and saturation helpers for the PID controller block.
// ----------------------------------------------------------------------------
package pidaw_pkg;

    localparam int DW        = 32;
    localparam int CFG_IDX_W = 3;
    localparam int DVD_W     = 64;
    localparam int DIV_CNT_W = 7;
    localparam int INC_REM_W = 40;

    localparam logic [CFG_IDX_W-1:0] CFG_TARGET = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PGAIN  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IGAIN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DGAIN  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DMIN   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DMAX   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDUP = 3'd6;

    localparam logic signed [DW-1:0] RST_TARGET = 32'sd0;
    localparam logic signed [DW-1:0] RST_PGAIN  = 32'sd65536;
    localparam logic signed [DW-1:0] RST_IGAIN  = 32'sd0;
    localparam logic signed [DW-1:0] RST_DGAIN  = 32'sd0;
    localparam logic signed [DW-1:0] RST_DMIN   = 32'sd0;
    localparam logic signed [DW-1:0] RST_DMAX   = 32'sd6553600;
    localparam logic [DW-2:0]        RST_WINDUP = 31'd3276800;

    localparam logic signed [DW-1:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DW-1:0] S32_MIN = 32'sh8000_0000;

    // floor(2^38 / 125): estimate of (mag / 8) / 125 from mag[40:9]
    localparam logic [DW-1:0]        INC_RCP   = 32'd2199023255;
    localparam logic [INC_REM_W-1:0] INC_STEP  = 40'd125;
    localparam logic [INC_REM_W-1:0] INC_STEP2 = 40'd250;
    localparam logic signed [DW:0]   SLOPE_SCALE = 33'sd1000;

    localparam logic [DIV_CNT_W-1:0] SLP_DIV_LEN = 7'd43;
    localparam int                   SLP_DIV_SHIFT = DVD_W - 43;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_LOAD,
        ST_CHECK,
        ST_MUL_INC,
        ST_MAG_INC,
        ST_RCP_INC,
        ST_REM_INC,
        ST_FIX_INC,
        ST_SUM,
        ST_MUL_SLP,
        ST_START_SLP,
        ST_DIV_SLP,
        ST_MUL_P,
        ST_MUL_I,
        ST_MUL_D,
        ST_ADD_D,
        ST_CLAMP,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic                 start;
        logic [DIV_CNT_W-1:0] len;
    } t_div_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_sts;

    function automatic logic signed [DW-1:0] f_sat34(input logic signed [33:0] v);
        if (v[33:31] == 3'b000 || v[33:31] == 3'b111) begin
            return v[DW-1:0];
        end
        return v[33] ? S32_MIN : S32_MAX;
    endfunction

    // floor(p / 65536), saturated
    function automatic logic signed [DW-1:0] f_qsat(input logic signed [63:0] p);
        if (p[63:47] == '0 || p[63:47] == '1) begin
            return p[47:16];
        end
        return p[63] ? S32_MIN : S32_MAX;
    endfunction

    function automatic logic signed [DW-1:0] f_quo_to_s32(input logic [DVD_W-1:0] mag,
                                                         input logic neg);
        if (!neg) begin
            return (mag > 64'h7FFF_FFFF) ? S32_MAX : mag[DW-1:0];
        end
        return (mag > 64'h8000_0000) ? S32_MIN : (~mag[DW-1:0] + 32'd1);
    endfunction

endpackage

// File: rtl/pidaw_if.sv
// ----------------------------------------------------------------------------
// pidaw_if
// Valid/ready channels for samples, results and register writes.
// ----------------------------------------------------------------------------
interface pidaw_in_if import pidaw_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic signed [DW-1:0] measured;
    logic [DW-1:0]        now_ms;
    logic                 restart;

    modport source (output valid, measured, now_ms, restart, input ready);
    modport sink   (input valid, measured, now_ms, restart, output ready);
endinterface

interface pidaw_out_if import pidaw_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic signed [DW-1:0] drive;
    logic signed [DW-1:0] error_now;
    logic signed [DW-1:0] integral_now;
    logic signed [DW-1:0] slope_now;

    modport source (output valid, drive, error_now, integral_now, slope_now, input ready);
    modport sink   (input valid, drive, error_now, integral_now, slope_now, output ready);
endinterface

interface pidaw_cfg_if import pidaw_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [DW-1:0]        data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/pidaw_div.sv
// ----------------------------------------------------------------------------
// pidaw_div
// Unsigned restoring divider, one quotient bit per cycle, left-aligned dividend.
// ----------------------------------------------------------------------------
module pidaw_div import pidaw_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_div_ctl          i_ctl,
    input  logic [DVD_W-1:0]  i_dividend,
    input  logic [DW-1:0]     i_divisor,
    output t_div_sts          o_sts,
    output logic [DVD_W-1:0]  o_quotient
);

    logic                 r_busy, n_busy;
    logic                 r_done, n_done;
    logic [DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic [DVD_W-1:0]     r_dvd, n_dvd;
    logic [DVD_W-1:0]     r_quo, n_quo;
    logic [DW-1:0]        r_rem, n_rem;
    logic [DW-1:0]        r_dsr, n_dsr;

    logic [DW:0]   w_trial;
    logic [DW+1:0] w_diff;
    logic          w_ge;

    assign w_trial = {r_rem, r_dvd[DVD_W-1]};
    assign w_diff  = {1'b0, w_trial} - {2'b00, r_dsr};
    assign w_ge    = ~w_diff[DW+1];

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_dvd  = r_dvd;
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_dsr  = r_dsr;
        if (i_ctl.start) begin
            n_busy = 1'b1;
            n_cnt  = i_ctl.len;
            n_dvd  = i_dividend;
            n_quo  = '0;
            n_rem  = '0;
            n_dsr  = i_divisor;
        end else if (r_busy) begin
            n_dvd = {r_dvd[DVD_W-2:0], 1'b0};
            n_quo = {r_quo[DVD_W-2:0], w_ge};
            n_rem = w_ge ? w_diff[DW-1:0] : w_trial[DW-1:0];
            n_cnt = r_cnt - DIV_CNT_W'(1);
            if (r_cnt == DIV_CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt <= n_cnt;
        r_dvd <= n_dvd;
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_dsr <= n_dsr;
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_quotient = r_quo;

endmodule

// File: rtl/pid_controller_antiwindup_unit.sv
// ----------------------------------------------------------------------------
// pid_controller_antiwindup_unit
// Q16.16 PID controller with clamped integral and clamped output.
// One request at a time: input ready is high only in idle. A result waits in the
// output state while the output register is full. A first sample or one with zero
// elapsed time skips the integral, slope and gain math. The slope divide runs
// 43 steps, one quotient bit per cycle; divide by 1000 is a reciprocal multiply.
// Reset: synchronous active low; configuration registers and controller state take reset values.
// ----------------------------------------------------------------------------
module pid_controller_antiwindup_unit import pidaw_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    pidaw_in_if.sink        i_in,
    pidaw_out_if.source     o_out,
    pidaw_cfg_if.sink       i_cfg
);

    t_state r_state, n_state;

    // configuration
    logic signed [DW-1:0] r_target, r_pgain, r_igain, r_dgain, r_dmin, r_dmax;
    logic [DW-2:0]        r_windup;

    // controller state
    logic                 r_first;
    logic signed [DW-1:0] r_sum, r_prev_err, r_held_drive, r_held_error, r_held_slope;
    logic [DW-1:0]        r_prev_time;

    // working registers
    logic signed [DW-1:0] r_meas;
    logic [DW-1:0]        r_now;
    logic                 r_restart;
    logic signed [DW-1:0] r_err;
    logic [DW-1:0]        r_dt;
    logic signed [63:0]   r_prod;
    logic                 r_neg;
    logic [DVD_W-1:0]     r_mag;
    logic [DW-1:0]        r_quo_est;
    logic [INC_REM_W-1:0] r_rem_inc;
    logic signed [DW-1:0] r_inc;
    logic signed [DW-1:0] r_slope;
    logic signed [33:0]   r_acc;
    logic signed [DW-1:0] r_res_drive, r_res_error, r_res_integ, r_res_slope;

    // output register
    logic                 r_out_valid;
    logic signed [DW-1:0] r_out_drive, r_out_error, r_out_integ, r_out_slope;

    logic signed [DW-1:0] w_err;
    logic [DW-1:0]        w_dt;
    logic signed [DW:0]   w_diff33;
    logic signed [DW:0]   w_mul_a, w_mul_b;
    logic signed [65:0]   w_mul_p;
    logic [DVD_W-1:0]     w_prod_mag;
    logic [INC_REM_W-1:0] w_q125, w_rem_inc;
    logic [DW:0]          w_quo_fix;
    logic [DVD_W-1:0]     w_inc_mag;
    logic signed [DW-1:0] w_sum_sat, w_lim, w_sum_clamp;
    logic signed [DW-1:0] w_term;
    logic signed [33:0]   w_acc_next;
    logic signed [DW-1:0] w_drive_sat, w_drive;
    logic signed [DW-1:0] w_quo;
    logic                 w_out_free;
    logic                 w_accept;
    t_div_ctl             w_div_ctl;
    t_div_sts             w_div_sts;
    logic [DVD_W-1:0]     w_div_dvd;
    logic [DW-1:0]        w_div_dsr;
    logic [DVD_W-1:0]     w_div_quo;

    pidaw_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_div_ctl),
        .i_dividend (w_div_dvd),
        .i_divisor  (w_div_dsr),
        .o_sts      (w_div_sts),
        .o_quotient (w_div_quo)
    );

    assign w_accept   = i_in.valid && i_in.ready;
    assign w_out_free = !r_out_valid || o_out.ready;

    assign w_err    = f_sat34({{2{r_target[DW-1]}}, r_target} - {{2{r_meas[DW-1]}}, r_meas});
    assign w_dt     = r_now - r_prev_time;
    assign w_diff33 = {r_err[DW-1], r_err} - {r_prev_err[DW-1], r_prev_err};
    assign w_mul_p  = w_mul_a * w_mul_b;

    assign w_prod_mag = r_prod[63] ? (~r_prod + 64'd1) : r_prod;
    assign w_quo      = f_quo_to_s32(w_div_quo, r_neg);

    // divide by 1000: estimate (mag / 8) / 125, then add back up to two steps
    assign w_q125    = {1'b0, r_prod[63:32], 7'b0} - {7'b0, r_prod[63:32], 1'b0}
                     - {8'b0, r_prod[63:32]};
    assign w_rem_inc = {2'b00, r_mag[40:3]} - w_q125;
    assign w_quo_fix = {1'b0, r_quo_est}
                     + ((r_rem_inc >= INC_STEP2) ? 33'd2 :
                        (r_rem_inc >= INC_STEP)  ? 33'd1 : 33'd0);
    assign w_inc_mag = (r_mag[DVD_W-1:41] != '0) ? '1 : {31'b0, w_quo_fix};

    assign w_sum_sat = f_sat34({{2{r_sum[DW-1]}}, r_sum} + {{2{r_inc[DW-1]}}, r_inc});
    assign w_lim     = $signed({1'b0, r_windup});
    always_comb begin
        if (w_sum_sat > w_lim) begin
            w_sum_clamp = w_lim;
        end else if (w_sum_sat < -w_lim) begin
            w_sum_clamp = -w_lim;
        end else begin
            w_sum_clamp = w_sum_sat;
        end
    end

    assign w_term     = f_qsat(r_prod);
    assign w_acc_next = r_acc + {{2{w_term[DW-1]}}, w_term};

    assign w_drive_sat = f_sat34(r_acc);
    always_comb begin
        if (w_drive_sat > r_dmax) begin
            w_drive = r_dmax;
        end else if (w_drive_sat < r_dmin) begin
            w_drive = r_dmin;
        end else begin
            w_drive = w_drive_sat;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:      if (i_in.valid) n_state = ST_LOAD;
            ST_LOAD:      n_state = ST_CHECK;
            ST_CHECK: begin
                if (r_first || w_dt == '0) begin
                    n_state = ST_OUT;
                end else begin
                    n_state = ST_MUL_INC;
                end
            end
            ST_MUL_INC:   n_state = ST_MAG_INC;
            ST_MAG_INC:   n_state = ST_RCP_INC;
            ST_RCP_INC:   n_state = ST_REM_INC;
            ST_REM_INC:   n_state = ST_FIX_INC;
            ST_FIX_INC:   n_state = ST_SUM;
            ST_SUM:       n_state = ST_MUL_SLP;
            ST_MUL_SLP:   n_state = ST_START_SLP;
            ST_START_SLP: n_state = ST_DIV_SLP;
            ST_DIV_SLP:   if (w_div_sts.done) n_state = ST_MUL_P;
            ST_MUL_P:     n_state = ST_MUL_I;
            ST_MUL_I:     n_state = ST_MUL_D;
            ST_MUL_D:     n_state = ST_ADD_D;
            ST_ADD_D:     n_state = ST_CLAMP;
            ST_CLAMP:     n_state = ST_OUT;
            ST_OUT:       if (w_out_free) n_state = ST_IDLE;
            default:      n_state = ST_IDLE;
        endcase
    end

    // state outputs: handshake, divider and multiplier operand select
    always_comb begin
        i_in.ready      = 1'b0;
        w_div_ctl.start = 1'b0;
        w_div_ctl.len   = SLP_DIV_LEN;
        w_div_dvd       = w_prod_mag;
        w_div_dsr       = r_dt;
        w_mul_a         = '0;
        w_mul_b         = '0;
        unique case (r_state)
            ST_IDLE: i_in.ready = 1'b1;
            ST_MUL_INC: begin
                w_mul_a = {r_err[DW-1], r_err};
                w_mul_b = {1'b0, r_dt};
            end
            ST_RCP_INC: begin
                w_mul_a = {1'b0, r_mag[40:9]};
                w_mul_b = {1'b0, INC_RCP};
            end
            ST_MUL_SLP: begin
                w_mul_a = w_diff33;
                w_mul_b = SLOPE_SCALE;
            end
            ST_START_SLP: begin
                w_div_ctl.start = 1'b1;
                w_div_dvd       = w_prod_mag << SLP_DIV_SHIFT;
            end
            ST_MUL_P: begin
                w_mul_a = {r_pgain[DW-1], r_pgain};
                w_mul_b = {r_err[DW-1], r_err};
            end
            ST_MUL_I: begin
                w_mul_a = {r_igain[DW-1], r_igain};
                w_mul_b = {r_sum[DW-1], r_sum};
            end
            ST_MUL_D: begin
                w_mul_a = {r_dgain[DW-1], r_dgain};
                w_mul_b = {r_slope[DW-1], r_slope};
            end
            default: ;
        endcase
    end

    assign i_cfg.ready = 1'b1;

    // control and controller state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_out_valid  <= 1'b0;
            r_target     <= RST_TARGET;
            r_pgain      <= RST_PGAIN;
            r_igain      <= RST_IGAIN;
            r_dgain      <= RST_DGAIN;
            r_dmin       <= RST_DMIN;
            r_dmax       <= RST_DMAX;
            r_windup     <= RST_WINDUP;
            r_first      <= 1'b1;
            r_sum        <= '0;
            r_prev_err   <= '0;
            r_prev_time  <= '0;
            r_held_drive <= '0;
            r_held_error <= '0;
            r_held_slope <= '0;
        end else begin
            r_state <= n_state;

            if (r_state == ST_OUT && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end

            if (i_cfg.valid) begin
                unique case (i_cfg.index)
                    CFG_TARGET: r_target <= i_cfg.data;
                    CFG_PGAIN:  r_pgain  <= i_cfg.data;
                    CFG_IGAIN:  r_igain  <= i_cfg.data;
                    CFG_DGAIN:  r_dgain  <= i_cfg.data;
                    CFG_DMIN:   r_dmin   <= i_cfg.data;
                    CFG_DMAX:   r_dmax   <= i_cfg.data;
                    CFG_WINDUP: r_windup <= i_cfg.data[DW-2:0];
                    default: ;
                endcase
            end

            case (r_state)
                ST_LOAD: begin
                    if (r_restart) begin
                        r_first      <= 1'b1;
                        r_sum        <= '0;
                        r_prev_err   <= '0;
                        r_prev_time  <= '0;
                        r_held_drive <= '0;
                        r_held_error <= '0;
                        r_held_slope <= '0;
                    end
                end
                ST_CHECK: begin
                    if (r_first) begin
                        r_prev_time <= r_now;
                        r_prev_err  <= r_err;
                        r_first     <= 1'b0;
                    end
                end
                ST_SUM: r_sum <= w_sum_clamp;
                ST_CLAMP: begin
                    r_prev_err   <= r_err;
                    r_prev_time  <= r_now;
                    r_held_error <= r_err;
                    r_held_slope <= r_slope;
                    r_held_drive <= w_drive;
                end
                default: ;
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    r_meas    <= i_in.measured;
                    r_now     <= i_in.now_ms;
                    r_restart <= i_in.restart;
                end
            end
            ST_LOAD: r_err <= w_err;
            ST_CHECK: begin
                r_dt        <= w_dt;
                r_res_drive <= r_first ? '0 : r_held_drive;
                r_res_error <= r_held_error;
                r_res_integ <= r_sum;
                r_res_slope <= r_held_slope;
            end
            ST_MUL_INC, ST_RCP_INC, ST_MUL_SLP: r_prod <= w_mul_p[63:0];
            ST_MAG_INC: begin
                r_neg <= r_prod[63];
                r_mag <= w_prod_mag;
            end
            ST_REM_INC: begin
                r_quo_est <= r_prod[63:32];
                r_rem_inc <= w_rem_inc;
            end
            ST_FIX_INC: r_inc <= f_quo_to_s32(w_inc_mag, r_neg);
            ST_START_SLP: r_neg <= r_prod[63];
            ST_DIV_SLP: if (w_div_sts.done) r_slope <= w_quo;
            ST_MUL_P: begin
                r_prod <= w_mul_p[63:0];
                r_acc  <= '0;
            end
            ST_MUL_I, ST_MUL_D: begin
                r_prod <= w_mul_p[63:0];
                r_acc  <= w_acc_next;
            end
            ST_ADD_D: r_acc <= w_acc_next;
            ST_CLAMP: begin
                r_res_drive <= w_drive;
                r_res_error <= r_err;
                r_res_integ <= r_sum;
                r_res_slope <= r_slope;
            end
            default: ;
        endcase

        if (r_state == ST_OUT && w_out_free) begin
            r_out_drive <= r_res_drive;
            r_out_error <= r_res_error;
            r_out_integ <= r_res_integ;
            r_out_slope <= r_res_slope;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.drive        = r_out_drive;
    assign o_out.error_now    = r_out_error;
    assign o_out.integral_now = r_out_integ;
    assign o_out.slope_now    = r_out_slope;

    a_ready_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !i_in.ready)
        else $error("input ready held after request accept");

    a_out_from_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out.valid) |-> $past(r_state == ST_OUT))
        else $error("result valid raised outside output state");

    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_sts.done |-> (r_state == ST_DIV_SLP))
        else $error("divider finished while not awaited");

    a_first_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CHECK && r_first) |=> (r_res_drive == '0))
        else $error("first sample drive not zero");

endmodule
